FILE: rtl/c2u_pkg.sv
// c2u_pkg: shared types, constants and the 0x80..0x9F code point table
// for the Windows-1252 to UTF-8 transcoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package c2u_pkg;

  // Widest code point the table yields is U+2122, so 14 bits suffice
  localparam int unsigned CP_W = 14;

  // UTF-8 framing bytes
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] CONT  = 8'h80;

  // Windows-1252 window that needs the table
  localparam logic [2:0] C1_TOP = 3'b100;

  // Bytes left to send after the current one
  localparam logic [1:0] REM_ONE   = 2'd0;
  localparam logic [1:0] REM_TWO   = 2'd1;
  localparam logic [1:0] REM_THREE = 2'd2;

  // Code point with end-of-text mark
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            eot;
  } cp_item_t;

  // Encoded character, b0 goes out first
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] rem;
    logic       eot;
  } enc_item_t;

  // Code points for bytes 0x80..0x9F; unassigned slots keep their C1 value
  function automatic logic [CP_W-1:0] high_map(input logic [4:0] idx);
    logic [CP_W-1:0] cp;
    case (idx)
      5'd0:  cp = 14'h20AC;
      5'd1:  cp = 14'h0081;
      5'd2:  cp = 14'h201A;
      5'd3:  cp = 14'h0192;
      5'd4:  cp = 14'h201E;
      5'd5:  cp = 14'h2026;
      5'd6:  cp = 14'h2020;
      5'd7:  cp = 14'h2021;
      5'd8:  cp = 14'h02C6;
      5'd9:  cp = 14'h2030;
      5'd10: cp = 14'h0160;
      5'd11: cp = 14'h2039;
      5'd12: cp = 14'h0152;
      5'd13: cp = 14'h008D;
      5'd14: cp = 14'h017D;
      5'd15: cp = 14'h008F;
      5'd16: cp = 14'h0090;
      5'd17: cp = 14'h2018;
      5'd18: cp = 14'h2019;
      5'd19: cp = 14'h201C;
      5'd20: cp = 14'h201D;
      5'd21: cp = 14'h2022;
      5'd22: cp = 14'h2013;
      5'd23: cp = 14'h2014;
      5'd24: cp = 14'h02DC;
      5'd25: cp = 14'h2122;
      5'd26: cp = 14'h0161;
      5'd27: cp = 14'h203A;
      5'd28: cp = 14'h0153;
      5'd29: cp = 14'h009D;
      5'd30: cp = 14'h017E;
      5'd31: cp = 14'h0178;
      default: cp = 14'h0000;
    endcase
    return cp;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cp1252_to_utf8_transcoder_top.sv
// Top level of the Windows-1252 to UTF-8 transcoder.
// Depends on c2u_pkg, c2u_map, c2u_enc and c2u_ser.
`timescale 1ns / 1ps
`default_nettype none

// Takes one Windows-1252 byte per input item and returns its UTF-8 bytes,
// one per output item, in order: one byte for 0x00..0x7F, two for 0xA0..0xFF
// and for the table entries below U+0800, three for the rest of 0x80..0x9F.
// out_tuser marks the last UTF-8 byte of a character and out_tlast rides on
// that byte when the input item carried in_tlast. The block holds no state
// beyond its pipeline and needs no setup after reset. Four register stages
// (input, code point lookup, encode, output) carry each item to the output,
// where the output register presents its first byte. A new item can be
// taken every cycle while the pipeline has room; sustained input is limited
// by the one-byte-wide output serializer, which needs one output handshake
// for each UTF-8 byte that an item yields.
module cp1252_to_utf8_transcoder_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // end_of_text
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata,  // [7:0] out_byte
  output      logic       out_tuser,  // [0] last_of_char
  output      logic       out_tlast   // text_done
);

  logic               map_valid;
  logic               map_ready;
  c2u_pkg::cp_item_t  map_item;
  logic               enc_valid;
  logic               enc_ready;
  c2u_pkg::enc_item_t enc_item;

  // Input register and table lookup
  c2u_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_eot   (in_tlast),
    .dn_valid (map_valid),
    .dn_ready (map_ready),
    .dn_item  (map_item)
  );

  // Byte split
  c2u_enc u_enc (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (map_valid),
    .up_ready (map_ready),
    .up_item  (map_item),
    .dn_valid (enc_valid),
    .dn_ready (enc_ready),
    .dn_item  (enc_item)
  );

  // Byte-at-a-time output
  c2u_ser u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (enc_valid),
    .up_ready      (enc_ready),
    .up_item       (enc_item),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_byte      (out_tdata),
    .out_last_char (out_tuser),
    .out_done      (out_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/c2u_map.sv
// c2u_map: input register stage and code point lookup stage.
// Depends on c2u_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2u_map (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_eot,
  output      logic              dn_valid,
  input  wire logic              dn_ready,
  output      c2u_pkg::cp_item_t dn_item
);

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_eot_r;
  logic              s2_valid_r;
  c2u_pkg::cp_item_t s2_item_r;
  c2u_pkg::cp_item_t s2_item_nxt;
  logic              s1_ready;
  logic              s2_ready;

  // Stage can load when empty or when its content moves on
  assign s2_ready = !s2_valid_r || dn_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Table only for the 0x80..0x9F window, else code point equals the byte
  always_comb begin
    s2_item_nxt.eot = s1_eot_r;
    if (s1_byte_r[7:5] == c2u_pkg::C1_TOP) begin
      s2_item_nxt.cp = c2u_pkg::high_map(s1_byte_r[4:0]);
    end else begin
      s2_item_nxt.cp = {{(c2u_pkg::CP_W-8){1'b0}}, s1_byte_r};
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_byte_r <= in_byte;
      s1_eot_r  <= in_eot;
    end
    if (s2_ready && s1_valid_r) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_item  = s2_item_r;

endmodule

`default_nettype wire

FILE: rtl/c2u_enc.sv
// c2u_enc: UTF-8 encode stage, code point to one, two or three bytes.
// Depends on c2u_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2u_enc (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output      logic               up_ready,
  input  wire c2u_pkg::cp_item_t  up_item,
  output      logic               dn_valid,
  input  wire logic               dn_ready,
  output      c2u_pkg::enc_item_t dn_item
);

  logic               valid_r;
  c2u_pkg::enc_item_t item_r;
  c2u_pkg::enc_item_t item_nxt;
  logic [c2u_pkg::CP_W-1:0] cp;

  assign cp       = up_item.cp;
  assign up_ready = !valid_r || dn_ready;

  // Byte split by code point range
  always_comb begin
    item_nxt.eot = up_item.eot;
    item_nxt.b2  = c2u_pkg::CONT | {2'b00, cp[5:0]};
    if (cp[13:7] == 7'd0) begin
      // ASCII passes as one byte
      item_nxt.b0  = {1'b0, cp[6:0]};
      item_nxt.b1  = c2u_pkg::CONT;
      item_nxt.rem = c2u_pkg::REM_ONE;
    end else if (cp[13:11] == 3'd0) begin
      item_nxt.b0  = c2u_pkg::LEAD2 | {3'b000, cp[10:6]};
      item_nxt.b1  = c2u_pkg::CONT | {2'b00, cp[5:0]};
      item_nxt.rem = c2u_pkg::REM_TWO;
    end else begin
      item_nxt.b0  = c2u_pkg::LEAD3 | {6'b000000, cp[13:12]};
      item_nxt.b1  = c2u_pkg::CONT | {2'b00, cp[11:6]};
      item_nxt.rem = c2u_pkg::REM_THREE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

`default_nettype wire

FILE: rtl/c2u_ser.sv
// c2u_ser: output register that sends an encoded character one byte per
// handshake. Depends on c2u_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2u_ser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output      logic               up_ready,
  input  wire c2u_pkg::enc_item_t up_item,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [7:0]         out_byte,
  output      logic               out_last_char,
  output      logic               out_done
);

  logic       valid_r;
  logic [7:0] b0_r;
  logic [7:0] b1_r;
  logic [7:0] b2_r;
  logic [1:0] rem_r;
  logic       eot_r;
  logic       last_byte;
  logic       take;

  assign last_byte = (rem_r == c2u_pkg::REM_ONE);
  assign take      = valid_r && out_ready;
  // Next item loads as the final byte of this one leaves
  assign up_ready  = !valid_r || (out_ready && last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Load a new character, or shift to the next byte
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      b0_r  <= up_item.b0;
      b1_r  <= up_item.b1;
      b2_r  <= up_item.b2;
      rem_r <= up_item.rem;
      eot_r <= up_item.eot;
    end else if (take && !last_byte) begin
      b0_r  <= b1_r;
      b1_r  <= b2_r;
      rem_r <= rem_r - 2'd1;
    end
  end

  assign out_valid     = valid_r;
  assign out_byte      = b0_r;
  assign out_last_char = last_byte;
  assign out_done      = last_byte && eot_r;

endmodule

`default_nettype wire

FILE: rtl/c2u_chk.sv
// c2u_chk: port-level checks for the transcoder top, bound to it below.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module c2u_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       in_tlast,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tuser,
  input wire logic       out_tlast
);

  // A stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output changed while stalled");

  // End of text only on the closing byte of a character
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("text_done without last_of_char");

  // A closing byte is ASCII or a continuation byte
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[7] == 1'b0) || (out_tdata[7:6] == 2'b10))
    else $error("closing byte is a lead byte");

  // A lead byte taken is followed at once by a continuation byte
  a_lead_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && (out_tdata[7:6] == 2'b11)
      |=> out_tvalid && (out_tdata[7:6] == 2'b10))
    else $error("lead byte not followed by continuation");

endmodule

bind cp1252_to_utf8_transcoder_top c2u_chk u_chk (.*);

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for cp1252_to_utf8_transcoder_top.
// Needs only the RTL: directed and random items, checked by typed bytes or a UTF-8 encoder.
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_ITEMS   = 482;
  localparam int PRESS_FIRST = 240;  // start of the no-gap window with a long output hold
  localparam int PRESS_LEN   = 30;
  localparam int RX_HOLD     = 40;   // cycles the receiver holds off during the pressure window
  localparam int DRAIN_IDX   = 360;  // sender waits here until every byte has come out
  localparam int TAIL_CYCLES = 12;

  // Code points for 0x80..0x9F, entry 0 in the lowest 16 bits
  localparam logic [32*16-1:0] C1_CODE_POINTS = {
    16'h0178, 16'h017E, 16'h009D, 16'h0153, 16'h203A, 16'h0161, 16'h2122, 16'h02DC,
    16'h2014, 16'h2013, 16'h2022, 16'h201D, 16'h201C, 16'h2019, 16'h2018, 16'h0090,
    16'h008F, 16'h017D, 16'h008D, 16'h0152, 16'h2039, 16'h0160, 16'h2030, 16'h02C6,
    16'h2021, 16'h2020, 16'h2026, 16'h201E, 16'h0192, 16'h201A, 16'h0081, 16'h20AC
  };

  typedef struct packed {
    logic [7:0] code_unit;
    logic       last_of_char;
    logic       text_done;
  } utf8_unit_t;

  // Directed row; n_typed == 0 means the encoder below supplies the bytes.
  // Typed bytes go out first from the top of typed_bytes.
  typedef struct packed {
    logic [7:0]  chr;
    logic        eot;
    logic [1:0]  n_typed;
    logic [23:0] typed_bytes;
  } smoke_row_t;

  smoke_row_t smoke_rows [22] = '{
    '{8'h00, 1'b0, 2'd1, 24'h000000},  // lowest byte
    '{8'h7F, 1'b1, 2'd1, 24'h7F0000},  // top of ASCII
    '{8'hA0, 1'b0, 2'd2, 24'hC2A000},  // bottom of Latin-1 range
    '{8'hFF, 1'b1, 2'd2, 24'hC3BF00},  // highest byte
    '{8'h80, 1'b0, 2'd3, 24'hE282AC},  // euro sign, first table entry
    '{8'h9F, 1'b0, 2'd0, 24'h000000},  // last table entry
    '{8'h81, 1'b0, 2'd2, 24'hC28100},  // unassigned slots keep their C1 value
    '{8'h8D, 1'b1, 2'd2, 24'hC28D00},
    '{8'h8F, 1'b0, 2'd2, 24'hC28F00},
    '{8'h90, 1'b0, 2'd2, 24'hC29000},
    '{8'h9D, 1'b1, 2'd2, 24'hC29D00},
    '{8'h83, 1'b0, 2'd0, 24'h000000},  // table entry below U+0800
    '{8'h99, 1'b1, 2'd0, 24'h000000},  // trademark sign
    '{8'h85, 1'b0, 2'd0, 24'h000000},
    '{8'h8A, 1'b0, 2'd0, 24'h000000},
    '{8'h98, 1'b0, 2'd0, 24'h000000},
    '{8'h55, 1'b0, 2'd0, 24'h000000},
    '{8'hAA, 1'b1, 2'd0, 24'h000000},
    '{8'h0F, 1'b0, 2'd0, 24'h000000},
    '{8'hF0, 1'b0, 2'd0, 24'h000000},
    '{8'h41, 1'b1, 2'd0, 24'h000000},
    '{8'h80, 1'b1, 2'd3, 24'hE282AC}   // three bytes with end of text
  };

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic       in_tlast;   // end_of_text
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tuser;  // [0] last_of_char
  logic       out_tlast;  // text_done

  utf8_unit_t pending_utf8 [$];
  utf8_unit_t want;
  int         mismatches = 0;
  int         bytes_seen = 0;
  int         rx_count   = 0;
  bit         rx_hold_req = 0;
  int         chars_by_len [4] = '{0, 0, 0, 0};
  int         eot_items = 0;

  cp1252_to_utf8_transcoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock, 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reset held from time zero, released at a falling edge
  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Hard limit on run time
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Append one expected byte at the tail of the queue
  task automatic queue_unit(input utf8_unit_t u);
    pending_utf8 = {pending_utf8, u};
  endtask

  // Queue the UTF-8 bytes one Windows-1252 character turns into
  task automatic encode_utf8(input logic [7:0] chr, input logic eot, output int n);
    logic [15:0] cp;
    if (chr < 8'h80) begin
      queue_unit('{chr, 1'b1, eot});
      n = 1;
    end else begin
      cp = (chr < 8'hA0) ? C1_CODE_POINTS[{chr[4:0], 4'b0000} +: 16] : {8'h00, chr};
      if (cp < 16'h0800) begin
        queue_unit('{{3'b110, cp[10:6]}, 1'b0, 1'b0});
        queue_unit('{{2'b10, cp[5:0]}, 1'b1, eot});
        n = 2;
      end else begin
        queue_unit('{{4'b1110, cp[15:12]}, 1'b0, 1'b0});
        queue_unit('{{2'b10, cp[11:6]}, 1'b0, 1'b0});
        queue_unit('{{2'b10, cp[5:0]}, 1'b1, eot});
        n = 3;
      end
    end
  endtask

  // Offer one item after a gap; returns at the edge where it is taken
  task automatic offer_char(input logic [7:0] chr, input logic eot, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= chr;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
  endtask

  // Sender: directed table, then random characters
  initial begin
    logic [7:0] chr;
    logic       eot;
    int         gap;
    int         sel;
    int         n;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    while (!rst_n) @(negedge clk);

    for (int i = 0; i < NUM_ITEMS; i++) begin
      if (i < $size(smoke_rows)) begin
        chr = smoke_rows[i].chr;
        eot = smoke_rows[i].eot;
      end else begin
        // spread across ASCII, the table window and Latin-1
        sel = $urandom_range(0, 9);
        if (sel < 4)      chr = 8'($urandom_range(8'h00, 8'h7F));
        else if (sel < 7) chr = 8'($urandom_range(8'h80, 8'h9F));
        else              chr = 8'($urandom_range(8'hA0, 8'hFF));
        eot = ($urandom_range(0, 7) == 0);
      end

      if (i >= PRESS_FIRST && i < PRESS_FIRST + PRESS_LEN) gap = 0;
      else if (i % 80 < 20) gap = 0;
      else gap = $urandom_range(0, 4);
      if (i == PRESS_FIRST) rx_hold_req = 1'b1;

      // let the block empty out completely once
      if (i == DRAIN_IDX) begin
        in_tvalid <= 1'b0;
        while (pending_utf8.size() != 0) @(posedge clk);
        @(negedge clk);
        gap = 0;
      end

      offer_char(chr, eot, gap);

      if (i < $size(smoke_rows) && smoke_rows[i].n_typed != 2'd0) begin
        n = smoke_rows[i].n_typed;
        for (int k = 0; k < n; k++)
          queue_unit('{smoke_rows[i].typed_bytes[23 - 8*k -: 8],
                       k == n - 1, (k == n - 1) && eot});
      end else begin
        encode_utf8(chr, eot, n);
      end
      chars_by_len[n]++;
      if (eot) eot_items++;
      @(negedge clk);
    end
    in_tvalid <= 1'b0;

    // Drain, then keep watching for stray bytes for TAIL_CYCLES
    while (pending_utf8.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_utf8.size() != 0) begin
      $error("%0d expected bytes never arrived", pending_utf8.size());
      mismatches++;
    end

    $display("Covered %0d characters: %0d one-byte, %0d two-byte, %0d three-byte",
             NUM_ITEMS, chars_by_len[1], chars_by_len[2], chars_by_len[3]);
    $display("%0d end-of-text marks, %0d UTF-8 bytes checked, %0d mismatches",
             eot_items, bytes_seen, mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: random stalls per byte, one long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        stall = RX_HOLD;
        rx_hold_req = 1'b0;
      end else if (rx_count % 90 < 25) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      rx_count++;
      @(negedge clk);
    end
  end

  // Compare each output item with the oldest expected byte
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      bytes_seen++;
      if (pending_utf8.size() == 0) begin
        $error("unexpected output byte %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_utf8.pop_front();
        if (out_tdata !== want.code_unit) begin
          $error("out_byte: expected %h, got %h", want.code_unit, out_tdata);
          mismatches++;
        end
        if (out_tuser !== want.last_of_char) begin
          $error("last_of_char: expected %b, got %b", want.last_of_char, out_tuser);
          mismatches++;
        end
        if (out_tlast !== want.text_done) begin
          $error("text_done: expected %b, got %b", want.text_done, out_tlast);
          mismatches++;
        end
      end
    end
  end

endmodule
